@@ rtl/foci_pkg.sv @@
package foci_pkg;

  localparam int ACC_W   = 40;
  localparam int SLOPE_W = 36;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [SLOPE_W-1:0] slope_t;

  localparam logic [1:0] METHOD_EULER = 2'd0;
  localparam logic [1:0] METHOD_HEUN  = 2'd1;
  localparam logic [1:0] METHOD_RK4   = 2'd2;

  localparam logic       KIND_RC        = 1'b0;
  localparam logic       KIND_THRESHOLD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_METHOD       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CIRCUIT_KIND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RC      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_R1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_R2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd5;

  localparam logic [31:0]        GAIN_RESET      = 32'd2147484;
  localparam logic signed [31:0] THRESHOLD_RESET = 32'sd10066330;

endpackage

@@ rtl/foci_div6.sv @@
module foci_div6 (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  foci_pkg::acc_t num,
  output logic          done,
  output foci_pkg::acc_t quo
);
  import foci_pkg::*;

  localparam int STEPS = ACC_W / 4;

  logic             busy;
  logic [3:0]       cnt;
  logic             neg;
  logic [ACC_W-1:0] x;
  logic [1:0]       rem;

  acc_t             mag;
  logic [5:0]       y;
  logic [11:0]      yq;
  logic [3:0]       qd;
  logic [5:0]       r6;

  always_comb begin
    mag = num[ACC_W-1] ? -num : num;
    mag = mag + acc_t'(3);
    y   = {rem, x[ACC_W-1 -: 4]};
    yq  = 12'(y) * 12'd43;
    qd  = yq[10:7];
    r6  = y - 6'(qd) * 6'd3;
  end

  assign quo = neg ? -acc_t'(x) : acc_t'(x);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= '0;
        neg  <= num[ACC_W-1];
        x    <= {1'b0, mag[ACC_W-1:1]};
        rem  <= '0;
      end else if (busy) begin
        x   <= {x[ACC_W-5:0], qd};
        rem <= r6[1:0];
        cnt <= cnt + 4'd1;
        if (cnt == 4'(STEPS - 1)) begin
          busy <= 1'b0;
        end
        done <= (cnt == 4'(STEPS - 1));
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/first_order_circuit_integrator.sv @@
// Channel  Signals                                   Handshake
// config   cfg_we, cfg_index, cfg_data               write when cfg_we high
// input    ve_now, ve_half, ve_next, first_step      in_valid / in_ready
// output   vout, saturated                           out_valid / out_ready
//
// One item at a time; in_ready is high only while the sequencer is idle.
// Each item computes S slopes (1 Euler, 2 Heun, 4 RK4) with P gain products
// per slope (1 RC, 1 or 2 threshold branch, 0 for the first slope of a first
// step); RK4 then divides the weighted slope sum by six. A single 32x32
// multiplier forms the products and a four-bit-per-cycle divider divides.
// Reset is synchronous; a held result stalls the sequencer at its last cycle.
module first_order_circuit_integrator #(
  parameter int VOLTAGE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [foci_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [31:0]                   ve_now,
  input  logic signed [31:0]                   ve_half,
  input  logic signed [31:0]                   ve_next,
  input  logic                                 first_step,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [31:0]                   vout,
  output logic                                 saturated
);
  import foci_pkg::*;

  localparam int CLIP_W = (VOLTAGE_WIDTH >= 32) ? 32 : VOLTAGE_WIDTH;
  localparam acc_t VMAX = ACC_W'((longint'(1) << (CLIP_W - 1)) - 1);
  localparam acc_t VMIN = -VMAX - acc_t'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OP   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_POST = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  function automatic logic [32:0] clip(acc_t x);
    if (x > VMAX) return {1'b1, VMAX[31:0]};
    if (x < VMIN) return {1'b1, VMIN[31:0]};
    return {1'b0, x[31:0]};
  endfunction

  function automatic acc_t half_round(acc_t n);
    acc_t m;
    acc_t h;
    m = n[ACC_W-1] ? -n : n;
    h = (m + acc_t'(1)) >>> 1;
    return n[ACC_W-1] ? -h : h;
  endfunction

  logic [1:0]         method;
  logic               circuit_kind;
  logic [31:0]        gain_rc;
  logic [31:0]        gain_r1;
  logic [31:0]        gain_r2;
  logic signed [31:0] threshold;

  logic [2:0]         state;
  logic [1:0]         stage;
  logic               term;
  logic signed [31:0] cap_voltage;
  logic signed [31:0] ve0;
  logic signed [31:0] veh;
  logic signed [31:0] ve1;
  logic signed [31:0] pt;
  logic [32:0]        mag;
  logic [31:0]        gsel;
  logic               msign;
  logic               mlast;
  logic [63:0]        prod;
  slope_t             kacc;
  acc_t               acc;
  acc_t               incr;

  logic signed [31:0] ve_sel;
  logic signed [33:0] d;
  logic [31:0]        g_op;
  logic               sub_op;
  logic               last_op;
  logic [64:0]        rsum;
  slope_t             r_ext;
  slope_t             kacc_next;
  acc_t               k_ext;
  acc_t               v_ext;
  acc_t               step_sum;
  acc_t               pt_inc;
  logic [32:0]        pt_clip;
  logic [32:0]        fin_clip;
  logic               div_start;
  logic               div_done;
  acc_t               div_quo;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    case (stage)
      2'd0:    ve_sel = ve0;
      2'd1:    ve_sel = (method == METHOD_HEUN) ? ve1 : veh;
      2'd2:    ve_sel = veh;
      default: ve_sel = ve1;
    endcase

    if (circuit_kind == KIND_RC) begin
      d       = 34'(ve_sel) - 34'(pt);
      g_op    = gain_rc;
      sub_op  = 1'b0;
      last_op = 1'b1;
    end else if (!term && (ve_sel > threshold)) begin
      d       = 34'(ve_sel) - 34'(threshold) - 34'(pt);
      g_op    = gain_r1;
      sub_op  = 1'b0;
      last_op = 1'b0;
    end else begin
      d       = 34'(pt);
      g_op    = gain_r2;
      sub_op  = 1'b1;
      last_op = 1'b1;
    end

    rsum = {1'b0, prod} + (mag[32] ? {1'b0, gsel, 32'd0} : 65'd0) + 65'(32'h4000_0000);
    r_ext = SLOPE_W'(rsum[64:31]);
    kacc_next = msign ? kacc - r_ext : kacc + r_ext;

    k_ext = ACC_W'(kacc);
    v_ext = ACC_W'(cap_voltage);

    if ((method != METHOD_HEUN) && (method != METHOD_EULER) &&
        ((stage == 2'd1) || (stage == 2'd2)))
      step_sum = acc + (k_ext <<< 1);
    else if (stage == 2'd0)
      step_sum = k_ext;
    else
      step_sum = acc + k_ext;

    if ((method == METHOD_HEUN) || (stage == 2'd2))
      pt_inc = k_ext;
    else
      pt_inc = half_round(k_ext);
    pt_clip  = clip(v_ext + pt_inc);
    fin_clip = clip(v_ext + incr);

    div_start = (state == S_POST) && (method != METHOD_EULER) &&
                (method != METHOD_HEUN) && (stage == 2'd3);
  end

  foci_div6 u_div6 (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (step_sum),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      method       <= METHOD_RK4;
      circuit_kind <= KIND_RC;
      gain_rc      <= GAIN_RESET;
      gain_r1      <= GAIN_RESET;
      gain_r2      <= GAIN_RESET;
      threshold    <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_METHOD:       method       <= cfg_data[1:0];
        REG_CIRCUIT_KIND: circuit_kind <= cfg_data[0];
        REG_GAIN_RC:      gain_rc      <= cfg_data;
        REG_GAIN_R1:      gain_r1      <= cfg_data;
        REG_GAIN_R2:      gain_r2      <= cfg_data;
        REG_THRESHOLD:    threshold    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cap_voltage <= '0;
      out_valid   <= 1'b0;
      stage       <= '0;
      term        <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FIN)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ve0   <= ve_now;
            veh   <= ve_half;
            ve1   <= ve_next;
            stage <= 2'd0;
            term  <= 1'b0;
            kacc  <= '0;
            if (first_step) begin
              cap_voltage <= '0;
              state       <= S_POST;
            end else begin
              pt    <= cap_voltage;
              state <= S_OP;
            end
          end
        end
        S_OP: begin
          mag   <= d[33] ? 33'(-d) : 33'(d);
          msign <= d[33] ^ sub_op;
          gsel  <= g_op;
          mlast <= last_op;
          if (!term) kacc <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= 64'(mag[31:0]) * 64'(gsel);
          state <= S_ACC;
        end
        S_ACC: begin
          kacc <= kacc_next;
          if (mlast) begin
            state <= S_POST;
          end else begin
            term  <= 1'b1;
            state <= S_OP;
          end
        end
        S_POST: begin
          term <= 1'b0;
          acc  <= step_sum;
          pt   <= pt_clip[31:0];
          if (method == METHOD_EULER) begin
            incr  <= k_ext;
            state <= S_FIN;
          end else if (method == METHOD_HEUN) begin
            if (stage == 2'd0) begin
              stage <= 2'd1;
              state <= S_OP;
            end else begin
              incr  <= half_round(step_sum);
              state <= S_FIN;
            end
          end else if (stage == 2'd3) begin
            state <= S_DIV;
          end else begin
            stage <= stage + 2'd1;
            state <= S_OP;
          end
        end
        S_DIV: begin
          if (div_done) begin
            incr  <= div_quo;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            vout        <= fin_clip[31:0];
            saturated   <= fin_clip[32];
            out_valid   <= 1'b1;
            cap_voltage <= fin_clip[31:0];
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
